>>> src/assert_macros.svh
// Assertion macros shared by the deque RTL.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Plain property, sampled on the rising clock, ignored while in reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/dqks_pkg.sv
// Shared types and codes for the deque with key search.
// No dependencies; imported by the controller, datapath and top level.
package dqks_pkg;

	typedef enum logic [2:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_POP_FRONT  = 3'd1,
		REQ_PUSH_REAR  = 3'd2,
		REQ_POP_REAR   = 3'd3,
		REQ_SEARCH     = 3'd4
	} req_e;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} stat_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP_WAIT,
		S_SCAN,
		S_FINISH
	} state_e;

	// controller -> datapath
	typedef struct packed {
		logic  load;        // latch request and key
		logic  push;        // write entry, move pointers
		logic  pop_rd;      // issue read of the entry to pop
		logic  pop_commit;  // capture popped word, move pointers
		logic  scan_start;  // read front entry, clear offset
		logic  scan_step;   // read next entry, advance offset
		logic  found;       // result: ok with position
		logic  set_res;     // result: given code, zero payload
		stat_e res_code;
		logic  out_load;    // move result into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] req;
		logic       full;
		logic       empty;
		logic       match;
		logic       last;
	} sts_t;

endpackage

>>> src/dqks_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dqks_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/dqks_ctrl.sv
// Controller FSM for the deque: sequences one request at a time.
// Depends on dqks_pkg.
module dqks_ctrl
	import dqks_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_e state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.res_code = STAT_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_FINISH;
				case (sts.req)
					REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
						cmd.set_res = 1'b1;
						if (sts.full) begin
							cmd.res_code = STAT_FULL;
						end else begin
							cmd.push = 1'b1;
						end
					end
					REQ_POP_FRONT, REQ_POP_REAR: begin
						if (sts.empty) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = STAT_EMPTY;
						end else begin
							cmd.pop_rd = 1'b1;
							state_d    = S_POP_WAIT;
						end
					end
					REQ_SEARCH: begin
						if (sts.empty) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = STAT_EMPTY;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					default: begin
						cmd.set_res = 1'b1;  // unused code: no effect
					end
				endcase
			end
			S_POP_WAIT: begin
				cmd.pop_commit = 1'b1;
				state_d        = S_FINISH;
			end
			S_SCAN: begin
				if (sts.match) begin
					cmd.found = 1'b1;
					state_d   = S_FINISH;
				end else if (sts.last) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = STAT_NOT_FOUND;
					state_d      = S_FINISH;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> src/dqks_dp.sv
// Datapath for the deque: ring pointers, entry RAM, scan and result registers.
// Depends on dqks_pkg and dqks_ram.
module dqks_dp
	import dqks_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] value,
	input  cmd_t               cmd,
	output sts_t               sts,
	output logic [1:0]         status,
	output logic signed [31:0] popped_value,
	output logic [4:0]         position
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] CAP_M1 = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [CW:0]   CAP_W  = (CW + 1)'(CAPACITY);

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
		return (i == CAP_M1) ? '0 : IW'(i + 1'b1);
	endfunction

	function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] i);
		return (i == '0) ? CAP_M1 : IW'(i - 1'b1);
	endfunction

	// front + off modulo CAPACITY, off never above CAPACITY
	function automatic logic [IW-1:0] slot_add(input logic [IW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = {{(CW + 1 - IW){1'b0}}, base} + {1'b0, off};
		if (sum >= CAP_W) begin
			sum = sum - CAP_W;
		end
		return sum[IW-1:0];
	endfunction

	logic [IW-1:0]      front_q;
	logic [CW-1:0]      count_q;
	logic [2:0]         req_q;
	logic signed [31:0] key_q;
	logic [IW-1:0]      scan_slot_q;
	logic [CW-1:0]      off_q;
	logic [1:0]         res_status_q;
	logic [31:0]        res_popped_q;
	logic [4:0]         res_pos_q;
	logic [1:0]         status_q;
	logic [31:0]        popped_q;
	logic [4:0]         pos_q;

	logic [IW-1:0] front_dec;
	logic [IW-1:0] rear_slot;
	logic [IW-1:0] last_slot;
	logic [IW-1:0] scan_next;
	logic [CW:0]   off_p1;
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [IW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	assign front_dec = wrap_dec(front_q);
	assign rear_slot = slot_add(front_q, count_q);
	assign last_slot = slot_add(front_q, CW'(count_q - 1'b1));
	assign scan_next = wrap_inc(scan_slot_q);
	assign off_p1    = {1'b0, off_q} + 1'b1;

	assign ram_we    = cmd.push;
	assign ram_waddr = (req_q == REQ_PUSH_FRONT) ? front_dec : rear_slot;

	always_comb begin
		ram_raddr = front_q;
		if (cmd.pop_rd && req_q == REQ_POP_REAR) begin
			ram_raddr = last_slot;
		end else if (cmd.scan_step) begin
			ram_raddr = scan_next;
		end
	end

	dqks_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata($unsigned(key_q)),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign sts.req   = req_q;
	assign sts.full  = (count_q == CAP_C);
	assign sts.empty = (count_q == '0);
	assign sts.match = (ram_rdata == $unsigned(key_q));
	assign sts.last  = (off_p1 == {1'b0, count_q});

	// ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.push) begin
			if (req_q == REQ_PUSH_FRONT) begin
				front_q <= front_dec;
			end
			count_q <= CW'(count_q + 1'b1);
		end else if (cmd.pop_commit) begin
			if (req_q == REQ_POP_FRONT) begin
				front_q <= wrap_inc(front_q);
			end
			count_q <= CW'(count_q - 1'b1);
		end
	end

	// request, scan and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			key_q <= value;
		end
		if (cmd.scan_start) begin
			scan_slot_q <= front_q;
			off_q       <= '0;
		end else if (cmd.scan_step) begin
			scan_slot_q <= scan_next;
			off_q       <= off_p1[CW-1:0];
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			res_popped_q <= '0;
			res_pos_q    <= '0;
		end else if (cmd.pop_commit) begin
			res_status_q <= STAT_OK;
			res_popped_q <= ram_rdata;
			res_pos_q    <= '0;
		end else if (cmd.found) begin
			res_status_q <= STAT_OK;
			res_popped_q <= '0;
			res_pos_q    <= 5'(off_p1);
		end
		if (cmd.out_load) begin
			status_q <= res_status_q;
			popped_q <= res_popped_q;
			pos_q    <= res_pos_q;
		end
	end

	assign status       = status_q;
	assign popped_value = $signed(popped_q);
	assign position     = pos_q;

endmodule

>>> src/deque_with_key_search.sv
// Top level of the bounded deque with key search.
// Depends on dqks_pkg, dqks_ctrl, dqks_dp, dqks_ram and assert_macros.svh.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  request | in        | in_valid / in_stall   | req_type, value
//  result  | out       | out_valid / out_stall | status, popped_value, position
//
// One request is in flight at a time. Push, full, empty and unused codes pass
// through EXEC and FINISH; a pop adds POP_WAIT for its RAM read. A search
// walks the store in SCAN from the front to the match or the last entry,
// one entry per cycle through the single RAM read port.
// Reset clears pointers, FSM and output valid; entry RAM is not cleared.
// A held result does not block the next accept; the FSM only waits for the
// output register to free up before it loads the next transaction's result.
`include "assert_macros.svh"

module deque_with_key_search
	import dqks_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] popped_value,
	output logic [4:0]         position
);

	cmd_t cmd;  // controller commands
	sts_t sts;  // datapath flags

	// sequencing and handshakes
	dqks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// ring store, pointers and result registers
	dqks_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (req_type),
		.value       (value),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.popped_value(popped_value),
		.position    (position)
	);

	// after a request is taken the block goes busy
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// result is only loaded into a free output register
	`ASSERT_IMPLIES(a_load_when_free, clk, arst_n, cmd.out_load, !out_valid || !out_stall)
	// a push never lands on a full store
	`ASSERT_IMPLIES(a_no_push_full, clk, arst_n, cmd.push, !sts.full)
	// datapath actions are mutually exclusive
	`ASSERT_AT(a_one_action, clk, arst_n,
		$onehot0({cmd.push, cmd.pop_rd, cmd.pop_commit, cmd.scan_start, cmd.scan_step}))

endmodule
